// ===== sv/gradient_noise_2d_assert.svh =====
// assertion macros for the gradient noise block
// checks use the including module's clock and reset signals
`ifndef GRADIENT_NOISE_2D_ASSERT_SVH
`define GRADIENT_NOISE_2D_ASSERT_SVH

`ifndef SYNTHESIS
`define GN2D_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("gradient_noise_2d: property failed");
`define GN2D_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("gradient_noise_2d: forbidden condition seen");
`else
`define GN2D_ASSERT(label, prop)
`define GN2D_ASSERT_NEVER(label, expr)
`endif

`endif

// ===== sv/gn2d_pkg.sv =====
// shared types, codes and fixed-point helpers of the gradient noise block
// no dependencies
package gn2d_pkg;

   localparam int GRID_SIZE_DEF = 256;
   localparam int FRAC_BITS_DEF = 8;
   localparam int COORD_W       = 16;
   localparam int NOISE_W       = 16;

   localparam logic OP_EVAL = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [1:0] GRAD_POS_X = 2'd0;
   localparam logic [1:0] GRAD_NEG_X = 2'd1;
   localparam logic [1:0] GRAD_POS_Y = 2'd2;
   localparam logic [1:0] GRAD_NEG_Y = 2'd3;

   // signed Q16 distance or dot product, -65536..65536
   typedef logic signed [17:0] dot_type;
   // eased weight, 0..65536
   typedef logic [16:0] ease_type;
   // quadratic factor 6t^2 - 15t + 10 of the quintic fade in Q16, 0..655360
   typedef logic [19:0] poly_type;

   localparam dot_type  DOT_ONE  = 18'sd65536;
   localparam ease_type EASE_MAX = 17'd65536;

   function automatic dot_type corner_dot(input logic [1:0] code, input dot_type dx,
                                          input dot_type dy);
      dot_type r;
      unique case (code)
         GRAD_POS_X: r = dx;
         GRAD_NEG_X: r = -dx;
         GRAD_POS_Y: r = dy;
         GRAD_NEG_Y: r = -dy;
      endcase
      return r;
   endfunction

   function automatic poly_type ease_poly(input logic [15:0] t2, input logic [15:0] u);
      logic signed [22:0] p;
      p = 23'sd655360 + 23'sd6 * $signed({7'b0, t2}) - 23'sd15 * $signed({7'b0, u});
      return p[22] ? '0 : p[19:0];
   endfunction

   function automatic ease_type ease_clamp(input logic [35:0] prod);
      logic [19:0] s;
      s = prod[35:16];
      return (s > 20'(EASE_MAX)) ? EASE_MAX : s[16:0];
   endfunction

   // a + floor((b - a) * s / 2^16)
   function automatic dot_type blend(input dot_type a, input dot_type b, input ease_type s);
      logic signed [18:0] diff;
      logic signed [36:0] prod;
      logic [20:0]        sum;
      diff = {b[17], b} - {a[17], a};
      prod = 37'(diff) * 37'($signed({1'b0, s}));
      sum  = {{3{a[17]}}, a} + prod[36:16];
      return sum[17:0];
   endfunction

   // floor((v + 1) / 2) in Q0.16, clamped to the output range
   function automatic logic [NOISE_W-1:0] noise_map(input dot_type v);
      logic signed [18:0] r;
      r = $signed({v[17], v}) + 19'sd65536;
      if (r[18]) begin
         return '0;
      end else if (r[17]) begin
         return '1;
      end else begin
         return r[16:1];
      end
   endfunction

endpackage

// ===== sv/gradient_noise_2d.sv =====
// Two-dimensional gradient noise over a wrapping square grid: an eight-stage pipeline that takes
// one request per clock while the result is not stalled and returns one noise value for each
// accepted evaluate request; a load request writes one gradient entry (an index past the table
// is dropped) and returns nothing. Throughput is one request per clock, set by the gradient table
// being held in four copies so that all four corners of a cell are read in the same cycle. A load
// writes as it leaves stage three, in order with the evaluates around it, so an evaluate right
// behind a load sees the new entry. Table entries power up undefined and must be loaded before
// use. A stalled result holds the whole pipeline.
// depends on gn2d_pkg and gradient_noise_2d_assert.svh
`include "gradient_noise_2d_assert.svh"

module gradient_noise_2d
   import gn2d_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [COORD_W-1:0] req_x_coord,
   input  logic [COORD_W-1:0] req_y_coord,
   input  logic [15:0]        req_entry_index,
   input  logic [1:0]         req_gradient_code,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [NOISE_W-1:0] rsp_noise_value
);

   localparam int IDX_W    = $clog2(GRID_SIZE);
   localparam int DEPTH    = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int UP_SHIFT = COORD_W - FRAC_BITS;
   localparam int INT_W    = (UP_SHIFT > 0) ? UP_SHIFT : 1;
   // ceil(2^32 / GRID_SIZE): exact quotient for integer parts this narrow
   localparam logic [31:0] RECIP =
      32'((64'd4294967296 + 64'(GRID_SIZE) - 64'd1) / 64'(GRID_SIZE));

   function automatic logic [IDX_W-1:0] cell_mod(input logic [INT_W-1:0] n,
                                                 input logic [INT_W-1:0] q);
      logic [31:0] r;
      r = 32'(n) - 32'(q) * 32'(GRID_SIZE);
      if (r >= 32'(GRID_SIZE)) begin
         r = r - 32'(GRID_SIZE);
      end
      return IDX_W'(r);
   endfunction

   function automatic logic [IDX_W-1:0] cell_next(input logic [IDX_W-1:0] c);
      return (c == IDX_W'(GRID_SIZE - 1)) ? '0 : c + 1'b1;
   endfunction

   logic [7:0] valid_ff, valid_in;
   logic       adv;

   // stage 0: request register
   logic               op0_ff;
   logic [COORD_W-1:0] x0_ff, y0_ff;
   logic [15:0]        idx0_ff;
   logic [1:0]         code0_ff;

   // stage 1: integer parts, quotient estimates, offsets, squares
   logic [INT_W-1:0]    nx1_in, ny1_in, nx1_ff, ny1_ff, qx1_ff, qy1_ff;
   logic [INT_W+31:0]   qxp, qyp;
   logic [15:0]         ux1_in, uy1_in, ux1_ff, uy1_ff, t2x1_ff, t2y1_ff;
   logic [31:0]         sqx, sqy;
   logic                op1_ff;
   logic [15:0]         idx1_ff;
   logic [1:0]          code1_ff;

   // stage 2: cell corners, cubes, polynomial
   logic [IDX_W-1:0] c0_in, r0_in, c0_ff, c1_ff, r0_ff, r1_ff;
   logic [31:0]      cbx, cby;
   logic [15:0]      t3x2_ff, t3y2_ff, ux2_ff, uy2_ff;
   poly_type         qpx2_ff, qpy2_ff;
   logic             op2_ff;
   logic [15:0]      idx2_ff;
   logic [1:0]       code2_ff;

   // stage 3: table addresses and eased weights
   logic [ADDR_W-1:0] base0, base1;
   logic [ADDR_W-1:0] addr3_in [4];
   logic [ADDR_W-1:0] addr3_ff [4];
   logic [35:0]       spx, spy;
   ease_type          sx3_ff, sy3_ff;
   logic [15:0]       ux3_ff, uy3_ff;
   logic              op3_ff;
   logic [15:0]       idx3_ff;
   logic [1:0]        code3_ff;
   logic              wr_en;

   // stage 4: gradient codes from the table copies
   logic [1:0]  code4 [4];
   ease_type    sx4_ff, sy4_ff;
   logic [15:0] ux4_ff, uy4_ff;

   // stage 5: corner dot products
   dot_type  dxa, dxb, dya, dyb;
   dot_type  dot5_ff [4];
   ease_type sx5_ff, sy5_ff;

   // stage 6: blend along y
   dot_type  left6_ff, right6_ff;
   ease_type sx6_ff;

   // stage 7: blend along x and output mapping
   logic [NOISE_W-1:0] noise7_ff;

   assign adv       = !(valid_ff[7] && rsp_stall);
   assign req_stall = !adv;

   always_comb begin
      valid_in = {valid_ff[6:4], valid_ff[3] && (op3_ff == OP_EVAL), valid_ff[2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      nx1_in = INT_W'(x0_ff >> FRAC_BITS);
      ny1_in = INT_W'(y0_ff >> FRAC_BITS);
      ux1_in = 16'(x0_ff << UP_SHIFT);
      uy1_in = 16'(y0_ff << UP_SHIFT);
      qxp    = (INT_W+32)'(nx1_in) * (INT_W+32)'(RECIP);
      qyp    = (INT_W+32)'(ny1_in) * (INT_W+32)'(RECIP);
      sqx    = 32'(ux1_in) * 32'(ux1_in);
      sqy    = 32'(uy1_in) * 32'(uy1_in);

      c0_in = cell_mod(nx1_ff, qx1_ff);
      r0_in = cell_mod(ny1_ff, qy1_ff);
      cbx   = 32'(t2x1_ff) * 32'(ux1_ff);
      cby   = 32'(t2y1_ff) * 32'(uy1_ff);

      base0       = ADDR_W'(32'(r0_ff) * 32'(GRID_SIZE));
      base1       = ADDR_W'(32'(r1_ff) * 32'(GRID_SIZE));
      addr3_in[0] = base0 + ADDR_W'(c0_ff);
      addr3_in[1] = base0 + ADDR_W'(c1_ff);
      addr3_in[2] = base1 + ADDR_W'(c0_ff);
      addr3_in[3] = base1 + ADDR_W'(c1_ff);
      spx         = 36'(t3x2_ff) * 36'(qpx2_ff);
      spy         = 36'(t3y2_ff) * 36'(qpy2_ff);

      wr_en = adv && valid_ff[3] && (op3_ff == OP_LOAD) && (32'(idx3_ff) < 32'(DEPTH));

      dxa = $signed({2'b0, ux4_ff});
      dya = $signed({2'b0, uy4_ff});
      dxb = dxa - DOT_ONE;
      dyb = dya - DOT_ONE;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op0_ff   <= req_operation;
         x0_ff    <= req_x_coord;
         y0_ff    <= req_y_coord;
         idx0_ff  <= req_entry_index;
         code0_ff <= req_gradient_code;

         nx1_ff   <= nx1_in;
         ny1_ff   <= ny1_in;
         qx1_ff   <= qxp[INT_W+31:32];
         qy1_ff   <= qyp[INT_W+31:32];
         ux1_ff   <= ux1_in;
         uy1_ff   <= uy1_in;
         t2x1_ff  <= sqx[31:16];
         t2y1_ff  <= sqy[31:16];
         op1_ff   <= op0_ff;
         idx1_ff  <= idx0_ff;
         code1_ff <= code0_ff;

         c0_ff    <= c0_in;
         r0_ff    <= r0_in;
         c1_ff    <= cell_next(c0_in);
         r1_ff    <= cell_next(r0_in);
         t3x2_ff  <= cbx[31:16];
         t3y2_ff  <= cby[31:16];
         qpx2_ff  <= ease_poly(t2x1_ff, ux1_ff);
         qpy2_ff  <= ease_poly(t2y1_ff, uy1_ff);
         ux2_ff   <= ux1_ff;
         uy2_ff   <= uy1_ff;
         op2_ff   <= op1_ff;
         idx2_ff  <= idx1_ff;
         code2_ff <= code1_ff;

         addr3_ff <= addr3_in;
         sx3_ff   <= ease_clamp(spx);
         sy3_ff   <= ease_clamp(spy);
         ux3_ff   <= ux2_ff;
         uy3_ff   <= uy2_ff;
         op3_ff   <= op2_ff;
         idx3_ff  <= idx2_ff;
         code3_ff <= code2_ff;

         sx4_ff   <= sx3_ff;
         sy4_ff   <= sy3_ff;
         ux4_ff   <= ux3_ff;
         uy4_ff   <= uy3_ff;

         // corners: top left, top right, bottom left, bottom right
         dot5_ff[0] <= corner_dot(code4[0], dxa, dya);
         dot5_ff[1] <= corner_dot(code4[1], dxb, dya);
         dot5_ff[2] <= corner_dot(code4[2], dxa, dyb);
         dot5_ff[3] <= corner_dot(code4[3], dxb, dyb);
         sx5_ff     <= sx4_ff;
         sy5_ff     <= sy4_ff;

         left6_ff   <= blend(dot5_ff[0], dot5_ff[2], sy5_ff);
         right6_ff  <= blend(dot5_ff[1], dot5_ff[3], sy5_ff);
         sx6_ff     <= sx5_ff;

         noise7_ff  <= noise_map(blend(left6_ff, right6_ff, sx6_ff));
      end
   end

   // one table copy per corner, all written by every load whose index lies in the table
   for (genvar k = 0; k < 4; k++) begin : g_copy
      logic [1:0] gt_mem [DEPTH];
      logic [1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en) begin
            gt_mem[ADDR_W'(idx3_ff)] <= code3_ff;
         end
         if (adv) begin
            rd_ff <= gt_mem[addr3_ff[k]];
         end
      end

      assign code4[k] = rd_ff;
   end

   assign rsp_valid       = valid_ff[7];
   assign rsp_noise_value = noise7_ff;

   `GN2D_ASSERT(a_load_drops_out, adv |=> valid_ff[4] == $past(valid_ff[3] && op3_ff == OP_EVAL))
   `GN2D_ASSERT(a_stall_holds_pipe, !adv |=> $stable(valid_ff))
   `GN2D_ASSERT_NEVER(a_col_in_grid, valid_ff[2] && (c0_ff >= GRID_SIZE || c1_ff >= GRID_SIZE))
   `GN2D_ASSERT_NEVER(a_row_in_grid, valid_ff[2] && (r0_ff >= GRID_SIZE || r1_ff >= GRID_SIZE))

endmodule

// ===== test/gradient_noise_2d_scoreboard.sv =====
`timescale 1ns / 100ps
// scoreboard of gradient_noise_2d: mirrors the gradient table, predicts each noise value
// from the accepted requests and compares it with the returned one; depends on gn2d_pkg
module gradient_noise_2d_scoreboard
   import gn2d_pkg::*;
#(
   parameter int GRID_SIZE = GRID_SIZE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_operation,
   input  logic [COORD_W-1:0] req_x_coord,
   input  logic [COORD_W-1:0] req_y_coord,
   input  logic [15:0]        req_entry_index,
   input  logic [1:0]         req_gradient_code,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [NOISE_W-1:0] rsp_noise_value,
   output int                 fail_count,
   output int                 pending
);

   localparam int     DEPTH = GRID_SIZE * GRID_SIZE;
   localparam longint ONE   = 65536;

   typedef struct {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [NOISE_W-1:0] noise;
   } noise_due_type;

   logic [1:0]    grad_copy [DEPTH];
   noise_due_type noise_due [$];
   noise_due_type oldest;

   task automatic report_mismatch(input string what);
      $display("%0t gradient_noise_2d: %s", $time, what);
      fail_count++;
   endtask

   // quintic fade 6t^5 - 15t^4 + 10t^3 in Q16, shifts are floors on signed values
   function automatic longint eased_weight(input longint u);
      longint t2, t3, q, s;
      t2 = (u * u) >>> 16;
      t3 = (t2 * u) >>> 16;
      q  = 6 * t2 - 15 * u + 10 * ONE;
      if (q < 0) begin
         q = 0;
      end
      s = (t3 * q) >>> 16;
      if (s > ONE) begin
         s = ONE;
      end
      return s;
   endfunction

   function automatic longint interp(input longint a, input longint b, input longint s);
      return a + (((b - a) * s) >>> 16);
   endfunction

   function automatic longint grad_dot(input int row, input int col, input longint dx,
                                       input longint dy);
      case (grad_copy[row * GRID_SIZE + col])
         GRAD_POS_X: return dx;
         GRAD_NEG_X: return -dx;
         GRAD_POS_Y: return dy;
         default:    return -dy;
      endcase
   endfunction

   function automatic logic [NOISE_W-1:0] noise_expect(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y);
      int     c0, c1, r0, r1;
      longint ux, uy, tl, tr, bl, br, left, right, v;
      c0 = int'(x >> FRAC_BITS) % GRID_SIZE;
      r0 = int'(y >> FRAC_BITS) % GRID_SIZE;
      c1 = (c0 + 1) % GRID_SIZE;
      r1 = (r0 + 1) % GRID_SIZE;
      ux = longint'(x & 16'((1 << FRAC_BITS) - 1)) << (16 - FRAC_BITS);
      uy = longint'(y & 16'((1 << FRAC_BITS) - 1)) << (16 - FRAC_BITS);
      tl = grad_dot(r0, c0, ux, uy);
      tr = grad_dot(r0, c1, ux - ONE, uy);
      bl = grad_dot(r1, c0, ux, uy - ONE);
      br = grad_dot(r1, c1, ux - ONE, uy - ONE);
      left  = interp(tl, bl, eased_weight(uy));
      right = interp(tr, br, eased_weight(uy));
      v = interp(left, right, eased_weight(ux)) + ONE;
      if (v < 0) begin
         v = 0;
      end
      v = v >>> 1;
      if (v > 65535) begin
         v = 65535;
      end
      return NOISE_W'(v);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         noise_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (noise_due.size() == 0) begin
               report_mismatch($sformatf("noise value %h with no evaluate request waiting",
                                         rsp_noise_value));
            end else begin
               oldest = noise_due.pop_front();
               if (rsp_noise_value !== oldest.noise) begin
                  report_mismatch($sformatf("noise at x=%h y=%h is %h, predicted %h",
                                            oldest.x, oldest.y, rsp_noise_value,
                                            oldest.noise));
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_operation == OP_LOAD) begin
               // indexes past the table are dropped
               if (req_entry_index < DEPTH) begin
                  grad_copy[req_entry_index] = req_gradient_code;
               end
            end else begin
               noise_due.push_back('{req_x_coord, req_y_coord,
                                     noise_expect(req_x_coord, req_y_coord)});
            end
         end
      end
      pending = noise_due.size();
   end

endmodule

// ===== test/gradient_noise_2d_tb.sv =====
`timescale 1ns / 100ps
// testbench top of gradient_noise_2d: clock, reset, request stimulus, result stalls and verdict
// depends on gn2d_pkg, gradient_noise_2d and gradient_noise_2d_scoreboard
module gradient_noise_2d_tb
   import gn2d_pkg::*;
();

   localparam int GRID           = GRID_SIZE_DEF;
   localparam int FRAC           = FRAC_BITS_DEF;
   localparam int REQUEST_TARGET = 1300;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 20;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_stall;
   logic               req_operation     = OP_EVAL;
   logic [COORD_W-1:0] req_x_coord       = '0;
   logic [COORD_W-1:0] req_y_coord       = '0;
   logic [15:0]        req_entry_index   = '0;
   logic [1:0]         req_gradient_code = GRAD_POS_X;
   logic               rsp_valid;
   logic               rsp_stall         = 1'b0;
   logic [NOISE_W-1:0] rsp_noise_value;
   int                 fail_count;
   int                 pending;

   int   idle_pct  = 10;
   int   stall_pct = 83;
   logic hold_req  = 1'b0;
   logic hold_used = 1'b0;
   int   hold_left = 0;
   int   quiet     = 0;
   int   sent      = 0;
   int   phase     = 1;
   bit   loaded [GRID * GRID];
   int   cells [$];

   always #1 clock = ~clock;

   gradient_noise_2d dut (.*);

   gradient_noise_2d_scoreboard scoreboard (.*);

   // result side: random stalls, plus one long hold-off so the pipeline backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
         $display("gradient_noise_2d_tb NOT OK");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic int cell_entry(input int row, input int col);
      return (row % GRID) * GRID + (col % GRID);
   endfunction

   task automatic offer(input logic op, input logic [COORD_W-1:0] x,
                        input logic [COORD_W-1:0] y, input logic [15:0] idx,
                        input logic [1:0] code);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_x_coord       <= x;
      req_y_coord       <= y;
      req_entry_index   <= idx;
      req_gradient_code <= code;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent++;
   endtask

   task automatic load_entry(input int idx, input logic [1:0] code);
      offer(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), 16'(idx), code);
      loaded[idx] = 1'b1;
   endtask

   task automatic set_cell(input int col, input int row, input logic [1:0] tl,
                           input logic [1:0] tr, input logic [1:0] bl, input logic [1:0] br);
      load_entry(cell_entry(row, col), tl);
      load_entry(cell_entry(row, col + 1), tr);
      load_entry(cell_entry(row + 1, col), bl);
      load_entry(cell_entry(row + 1, col + 1), br);
   endtask

   // fills in any unloaded corner first so the evaluate never reads an unwritten entry
   task automatic eval_at(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      int col, row, e, k;
      col = int'(x >> FRAC) % GRID;
      row = int'(y >> FRAC) % GRID;
      for (k = 0; k < 4; k++) begin
         e = cell_entry(row + k / 2, col + k % 2);
         if (!loaded[e]) begin
            load_entry(e, 2'($urandom));
         end
      end
      offer(OP_EVAL, x, y, 16'($urandom), 2'($urandom));
      cells.push_back(cell_entry(row, col));
      if (cells.size() > 64) begin
         void'(cells.pop_front());
      end
   endtask

   function automatic logic [COORD_W-1:0] coord_in(input int cell_pos);
      return COORD_W'((cell_pos << FRAC) | $urandom_range((1 << FRAC) - 1));
   endfunction

   initial begin
      int choice, pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // table index extremes, origin cell and the cell that wraps on both axes
      load_entry(0, GRAD_POS_X);
      load_entry(GRID * GRID - 1, GRAD_NEG_Y);
      eval_at(16'h0000, 16'h0000);
      eval_at(16'hFFFF, 16'hFFFF);
      // x gradients pointing inward: strongest positive values
      set_cell(10, 10, GRAD_POS_X, GRAD_NEG_X, GRAD_POS_X, GRAD_NEG_X);
      eval_at(16'h0A80, 16'h0A80);
      eval_at(16'h0AFF, 16'h0A00);
      // y gradients pointing outward: negative values
      set_cell(20, 20, GRAD_NEG_Y, GRAD_NEG_Y, GRAD_POS_Y, GRAD_POS_Y);
      eval_at(16'h1480, 16'h1480);
      eval_at(16'h1400, 16'h14FF);

      while (sent < REQUEST_TARGET) begin
         if (phase == 1 && sent >= REQUEST_TARGET / 3) begin
            phase = 2;
            idle_pct = 83;
            stall_pct <= 10;
         end else if (phase == 2 && sent >= 2 * REQUEST_TARGET / 3) begin
            phase = 3;
            idle_pct = 0;
            stall_pct <= 0;
            hold_req <= 1'b1;
         end
         choice = $urandom_range(99);
         pick = cells[$urandom_range(cells.size() - 1)];
         if (choice < 15) begin
            load_entry($urandom_range(GRID * GRID - 1), 2'($urandom));
         end else if (choice < 30) begin
            // rewrite a corner of a recent cell so later evaluates see the new gradient
            choice = $urandom_range(3);
            load_entry(cell_entry(pick / GRID + choice / 2, pick % GRID + choice % 2),
                       2'($urandom));
         end else if (choice < 65) begin
            eval_at(COORD_W'($urandom), COORD_W'($urandom));
         end else begin
            eval_at(coord_in(pick % GRID), coord_in(pick / GRID));
         end
      end
      req_valid <= 1'b0;

      do begin
         @(negedge clock);
      end while (pending != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("gradient_noise_2d_tb OK");
      end else begin
         $display("gradient_noise_2d_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/gn2d_pkg.sv
sv/gradient_noise_2d.sv
test/gradient_noise_2d_scoreboard.sv
test/gradient_noise_2d_tb.sv
